@@ sv/mpld_pkg.sv @@
`timescale 1ns / 1ps
package mpld_pkg;

  // Fixed widths of the register file and result fields.
  localparam int unsigned ACC_W  = 30;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned FLD_W  = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned NFLOOR_W = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_ASYM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_ASYM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_FLOOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT  = 3'd4;

  // Status returned by the percent divider.
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/mpld_div.sv @@
`timescale 1ns / 1ps
// Percent difference |x - y| * 100 / max(x, y) by restoring division,
// one quotient bit per cycle. The quotient never exceeds 100.
module mpld_div #(
  parameter int unsigned W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [W-1:0]      x_i,
  input  logic [W-1:0]      y_i,
  output mpld_pkg::div_rsp_t rsp_o
);
  import mpld_pkg::*;

  localparam int unsigned NW = W + PCT_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             zero_q, zero_d;
  logic [2:0]       k_q, k_d;
  logic [NW-1:0]    rem_q, rem_d;
  logic [W-1:0]     big_q, big_d;
  logic [PCT_W-1:0] quo_q, quo_d;

  logic [W-1:0]  big, diff;
  logic [NW-1:0] diff_w, trial;

  always_comb begin
    big    = (x_i > y_i) ? x_i : y_i;
    diff   = (x_i > y_i) ? (x_i - y_i) : (y_i - x_i);
    diff_w = NW'(diff);
    trial  = NW'(big_q) << k_q;

    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    k_d    = k_q;
    rem_d  = rem_q;
    big_d  = big_q;
    quo_d  = quo_q;

    if (start_i) begin
      busy_d = 1'b1;
      zero_d = (big == '0);
      k_d    = 3'd6;
      rem_d  = (diff_w << 6) + (diff_w << 5) + (diff_w << 2);
      big_d  = big;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d     = rem_q - trial;
        quo_d[k_q] = 1'b1;
      end
      if (k_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    k_q    <= k_d;
    rem_q  <= rem_d;
    big_q  <= big_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = zero_q ? '0 : quo_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a running division");
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rsp_o.quo <= PCT_W'(100))) else $error("percent above 100");
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && k_q != 3'd0) |=> busy_q) else $error("division cut short");
`endif

endmodule

@@ sv/motor_phase_loss_detector_core.sv @@
`timescale 1ns / 1ps
// Three-phase phase-loss monitor. A sample word (kind 0) adds the magnitudes of
// the three currents and voltages into six leaky accumulators, one accumulator
// per cycle through a shared adder; a sample word taken while the motor is not
// spinning leaves them as they are. A check word (kind 1) returns one result
// word through the output register; with refresh on a spinning motor it first
// runs six percent divisions on one shared restoring divider. One word is in
// work at a time and in_stall_o is high meanwhile; a finished result waits in
// the output register, and the next word is taken as soon as the sequencer has
// handed its result over.
module motor_phase_loss_detector_core #(
  parameter int unsigned AVG_SHIFT    = 14,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic                             spinning_i,
  input  logic                             refresh_i,
  input  logic signed [15:0]               cur_a_i,
  input  logic signed [15:0]               cur_b_i,
  input  logic signed [15:0]               cur_c_i,
  input  logic signed [15:0]               volt_a_i,
  input  logic signed [15:0]               volt_b_i,
  input  logic signed [15:0]               volt_c_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             fault_o,
  output logic                             phase_corrupted_o,
  output logic                             phase_lost_o,
  output logic                             phase_asymmetric_o,
  output logic [15:0]                      error_count_o,
  output logic [6:0]                       max_volt_diff_o,
  output logic [6:0]                       max_curr_diff_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mpld_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mpld_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mpld_pkg::*;

  localparam int unsigned AVG_W = ACC_W - AVG_SHIFT;
  localparam int unsigned CW    = (AVG_W > NFLOOR_W) ? AVG_W : NFLOOR_W;
  localparam int unsigned SW3   = ((AVG_W + 2) > 17) ? (AVG_W + 2) : 17;
  localparam logic [ACC_W:0] ACC_MAX = {1'b0, {ACC_W{1'b1}}};
  localparam logic [SAMPLE_WIDTH:0] MAG_FULL = (SAMPLE_WIDTH + 1)'(1) << SAMPLE_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // Configuration registers.
  logic [PCT_W-1:0]    volt_thr_q, curr_thr_q;
  logic [NFLOOR_W-1:0] curr_floor_q, volt_floor_q;
  logic [CNT_W-1:0]    err_limit_q;

  // Control and monitor state.
  logic [2:0]       state_q, state_d;
  logic [2:0]       idx_q, idx_d;
  logic [ACC_W-1:0] acc_q [6];
  logic [ACC_W-1:0] acc_new;
  logic             acc_we;
  logic             static_q, static_d;
  logic             cur_sym_q, cur_sym_d;
  logic             volt_sym_q, volt_sym_d;
  logic             svalid_q, svalid_d;
  logic             lost_q, lost_d;
  logic             asym_q, asym_d;
  logic             corr_q, corr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PCT_W-1:0] peak_v_q, peak_v_d, peak_c_q, peak_c_d;

  // Captured input word.
  logic             kind_q, spin_q, refresh_q;
  logic [FLD_W-1:0] fld_q [6];

  // Output register.
  logic             out_valid_q, out_valid_d, out_load;
  logic             fault_q, ocorr_q, olost_q, oasym_q;
  logic [CNT_W-1:0] ocnt_q;
  logic [PCT_W-1:0] opv_q, opc_q;

  logic in_accept;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Averages and noise-floor clamped currents.
  logic [AVG_W-1:0] cavg [3], vavg [3], ph [3];
  logic [SW3-1:0]   ph_sum, floor3;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cavg[i] = acc_q[i][ACC_W-1:AVG_SHIFT];
      vavg[i] = acc_q[3+i][ACC_W-1:AVG_SHIFT];
      ph[i]   = (CW'(cavg[i]) < CW'(curr_floor_q)) ? AVG_W'(1) : cavg[i];
    end
    ph_sum = SW3'(ph[0]) + SW3'(ph[1]) + SW3'(ph[2]);
    floor3 = SW3'(curr_floor_q) + SW3'(curr_floor_q) + SW3'(curr_floor_q) + SW3'(2);
  end

  // Static-vector test on the check word's own averages.
  logic [1:0] nstatic;
  always_comb begin
    logic [14:0] pos, neg, p75, n75;
    logic [15:0] sum;
    logic [14:0] half;
    nstatic = '0;
    for (int i = 0; i < 3; i++) begin
      pos  = fld_q[i][15]   ? '0 : fld_q[i][14:0];
      neg  = fld_q[3+i][15] ? '0 : fld_q[3+i][14:0];
      sum  = {1'b0, pos} + {1'b0, neg};
      half = sum[15:1];
      p75  = (pos >> 1) + (pos >> 2);
      n75  = (neg >> 1) + (neg >> 2);
      if ((half < p75) || (half < n75)) begin
        nstatic = nstatic + 2'd1;
      end
    end
  end

  // Shared accumulator adder: leak, add magnitude, saturate.
  always_comb begin
    logic [SAMPLE_WIDTH-1:0] w;
    logic [SAMPLE_WIDTH:0]   mag;
    logic [ACC_W-1:0]        cur;
    logic [ACC_W:0]          sum;
    w   = fld_q[idx_q][SAMPLE_WIDTH-1:0];
    mag = w[SAMPLE_WIDTH-1] ? (MAG_FULL - {1'b0, w}) : {1'b0, w};
    cur = acc_q[idx_q];
    sum = {1'b0, cur - (cur >> AVG_SHIFT)} + (ACC_W + 1)'(mag);
    acc_new = (sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : sum[ACC_W-1:0];
  end

  // Divider operand selection: three current pairs, then three voltage pairs.
  logic [AVG_W-1:0]  dx, dy;
  logic              div_start;
  div_rsp_t          div_rsp;
  always_comb begin
    case (idx_q)
      3'd0: begin dx = ph[0];   dy = ph[1];   end
      3'd1: begin dx = ph[1];   dy = ph[2];   end
      3'd2: begin dx = ph[2];   dy = ph[0];   end
      3'd3: begin dx = vavg[0]; dy = vavg[1]; end
      3'd4: begin dx = vavg[1]; dy = vavg[2]; end
      default: begin dx = vavg[2]; dy = vavg[0]; end
    endcase
  end

  mpld_div #(.W(AVG_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .x_i    (dx),
    .y_i    (dy),
    .rsp_o  (div_rsp)
  );

  // Sequencer.
  always_comb begin
    logic any_zero, corrupted;
    state_d    = state_q;
    idx_d      = idx_q;
    acc_we     = 1'b0;
    div_start  = 1'b0;
    static_d   = static_q;
    cur_sym_d  = cur_sym_q;
    volt_sym_d = volt_sym_q;
    svalid_d   = svalid_q;
    lost_d     = lost_q;
    asym_d     = asym_q;
    corr_d     = corr_q;
    cnt_d      = cnt_q;
    peak_v_d   = peak_v_q;
    peak_c_d   = peak_c_q;
    out_load   = 1'b0;
    any_zero   = 1'b0;
    corrupted  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          idx_d  = '0;
          corr_d = 1'b0;
          if (!kind_i) begin
            state_d = spinning_i ? S_ACC : S_IDLE;
          end else if (!spinning_i) begin
            state_d = S_OUT;
          end else begin
            state_d = refresh_i ? S_EVAL : S_DECIDE;
          end
        end
      end
      S_ACC: begin
        acc_we = 1'b1;
        if (idx_q == 3'd5) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      S_EVAL: begin
        static_d   = (nstatic >= 2'd2);
        svalid_d   = (ph_sum > floor3);
        cur_sym_d  = 1'b1;
        volt_sym_d = 1'b1;
        idx_d      = '0;
        state_d    = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          if (idx_q < 3'd3) begin
            if (div_rsp.quo > curr_thr_q) cur_sym_d = 1'b0;
            if (div_rsp.quo > peak_c_q)   peak_c_d  = div_rsp.quo;
          end else begin
            if (div_rsp.quo > volt_thr_q) volt_sym_d = 1'b0;
            if (div_rsp.quo > peak_v_q)   peak_v_d   = div_rsp.quo;
          end
          if (idx_q == 3'd5) begin
            state_d = S_DECIDE;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = S_DSTART;
          end
        end
      end
      S_DECIDE: begin
        for (int i = 0; i < 3; i++) begin
          if ((CW'(vavg[i]) > CW'(volt_floor_q)) && (CW'(cavg[i]) < CW'(curr_floor_q))) begin
            any_zero = 1'b1;
          end
        end
        corrupted = (!volt_sym_q || !cur_sym_q) && svalid_q && !static_q;
        corr_d    = corrupted;
        if (corrupted) begin
          if (any_zero) lost_d = 1'b1;
          else          asym_d = 1'b1;
          if (cnt_q != '1) cnt_d = cnt_q + CNT_W'(1);
        end else begin
          lost_d = 1'b0;
          asym_d = 1'b0;
          if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)                       out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      static_q     <= 1'b0;
      cur_sym_q    <= 1'b0;
      volt_sym_q   <= 1'b0;
      svalid_q     <= 1'b0;
      lost_q       <= 1'b0;
      asym_q       <= 1'b0;
      corr_q       <= 1'b0;
      cnt_q        <= '0;
      peak_v_q     <= '0;
      peak_c_q     <= '0;
      out_valid_q  <= 1'b0;
      volt_thr_q   <= PCT_W'(20);
      curr_thr_q   <= PCT_W'(20);
      curr_floor_q <= NFLOOR_W'(600);
      volt_floor_q <= NFLOOR_W'(400);
      err_limit_q  <= CNT_W'(700);
      for (int i = 0; i < 6; i++) acc_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      static_q    <= static_d;
      cur_sym_q   <= cur_sym_d;
      volt_sym_q  <= volt_sym_d;
      svalid_q    <= svalid_d;
      lost_q      <= lost_d;
      asym_q      <= asym_d;
      corr_q      <= corr_d;
      cnt_q       <= cnt_d;
      peak_v_q    <= peak_v_d;
      peak_c_q    <= peak_c_d;
      out_valid_q <= out_valid_d;
      if (acc_we) acc_q[idx_q] <= acc_new;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_VOLT_ASYM:  volt_thr_q   <= cfg_data_i[PCT_W-1:0];
          CFG_CURR_ASYM:  curr_thr_q   <= cfg_data_i[PCT_W-1:0];
          CFG_CURR_FLOOR: curr_floor_q <= cfg_data_i[NFLOOR_W-1:0];
          CFG_VOLT_FLOOR: volt_floor_q <= cfg_data_i[NFLOOR_W-1:0];
          CFG_ERR_LIMIT:  err_limit_q  <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= kind_i;
      spin_q    <= spinning_i;
      refresh_q <= refresh_i;
      fld_q[0]  <= cur_a_i;
      fld_q[1]  <= cur_b_i;
      fld_q[2]  <= cur_c_i;
      fld_q[3]  <= volt_a_i;
      fld_q[4]  <= volt_b_i;
      fld_q[5]  <= volt_c_i;
    end
    if (out_load) begin
      fault_q <= (cnt_q > err_limit_q);
      ocorr_q <= corr_q;
      olost_q <= lost_q;
      oasym_q <= asym_q;
      ocnt_q  <= cnt_q;
      opv_q   <= peak_v_q;
      opc_q   <= peak_c_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fault_o            = fault_q;
  assign phase_corrupted_o  = ocorr_q;
  assign phase_lost_o       = olost_q;
  assign phase_asymmetric_o = oasym_q;
  assign error_count_o      = ocnt_q;
  assign max_volt_diff_o    = opv_q;
  assign max_curr_diff_o    = opc_q;

`ifndef SYNTHESIS
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)) ||
    (cnt_q == $past(cnt_q) - CNT_W'(1))) else $error("error counter jumped");
  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peak_v_q >= $past(peak_v_q)) && (peak_c_q >= $past(peak_c_q)))
    else $error("peak difference decreased");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("result without a check");
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DWAIT)) else $error("divider result unclaimed");
  a_cfg_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (!kind_q && spin_q)) else $error("accumulating on a check word");
  a_eval_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (kind_q && refresh_q)) else $error("evaluation without refresh");
`endif

endmodule

@@ test/motor_phase_loss_detector_core_test.sv @@
`timescale 1ns / 1ps
module motor_phase_loss_detector_core_test;
  import mpld_pkg::*;

  localparam int unsigned SHIFT = 14;
  localparam int unsigned ACC_TOP = 30'h3FFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CHECK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // A result word as the block reports it.
  typedef struct packed {
    logic        fault;
    logic        corrupted;
    logic        lost;
    logic        asym;
    logic [15:0] count;
    logic [6:0]  vdiff;
    logic [6:0]  cdiff;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0, spinning_i = 1'b0, refresh_i = 1'b0;
  logic signed [15:0] cur_a_i = '0, cur_b_i = '0, cur_c_i = '0;
  logic signed [15:0] volt_a_i = '0, volt_b_i = '0, volt_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic fault_o, phase_corrupted_o, phase_lost_o, phase_asymmetric_o;
  logic [15:0] error_count_o;
  logic [6:0] max_volt_diff_o, max_curr_diff_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  motor_phase_loss_detector_core u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Own copy of the monitor's registers and state.
  logic [6:0]  thr_volt, thr_curr;
  logic [14:0] floor_curr, floor_volt;
  logic [15:0] err_limit;
  logic [29:0] acc [6];
  logic        static_vec, curr_sym, volt_sym, valid_smp, lost_q, asym_q;
  logic [15:0] err_cnt;
  logic [6:0]  peak_v, peak_c;

  status_t expected_status[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned checks_seen = 0;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  function automatic logic [31:0] mag16(logic [15:0] w);
    return w[15] ? 32'h1_0000 - w : {16'h0, w};
  endfunction

  function automatic logic [31:0] pos16(logic [15:0] w);
    return w[15] ? 32'd0 : {16'h0, w};
  endfunction

  function automatic logic [31:0] percent_gap(logic [31:0] x, logic [31:0] y);
    logic [31:0] big, d;
    big = (x > y) ? x : y;
    d = (x > y) ? x - y : y - x;
    if (big == 0) return 0;
    return (64'(d) * 100) / big;
  endfunction

  // Returns 1 when all three pairs lie within the threshold; raises the peak.
  function automatic logic pairs_within(logic [31:0] v[3], logic [6:0] thr,
                                        ref logic [6:0] peak);
    logic sym;
    logic [31:0] d;
    sym = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d = percent_gap(v[i], v[(i + 1) % 3]);
      if (d > thr) sym = 1'b0;
      if (d > peak) peak = d[6:0];
    end
    return sym;
  endfunction

  task automatic reset_monitor_model();
    thr_volt = 20; thr_curr = 20; floor_curr = 600; floor_volt = 400; err_limit = 700;
    foreach (acc[i]) acc[i] = '0;
    {static_vec, curr_sym, volt_sym, valid_smp, lost_q, asym_q} = '0;
    err_cnt = '0; peak_v = '0; peak_c = '0;
  endtask

  // Works out what one word does; a check word queues its expected status.
  task automatic predict_word(logic kind, logic spin, logic refr, logic [15:0] f[6]);
    logic [31:0] cavg[3], vavg[3], ph[3], sum, hf, p75, n75, p, n;
    logic [63:0] a;
    logic corrupted, any_zero;
    int nstatic;
    status_t st;
    corrupted = 1'b0;
    if (kind == KIND_SAMPLE) begin
      if (spin) begin
        for (int i = 0; i < 6; i++) begin
          a = acc[i];
          a = a - (a >> SHIFT) + mag16(f[i]);
          acc[i] = (a > ACC_TOP) ? ACC_TOP[29:0] : a[29:0];
        end
      end
      return;
    end
    if (spin) begin
      for (int i = 0; i < 3; i++) begin
        cavg[i] = acc[i] >> SHIFT;
        vavg[i] = acc[3 + i] >> SHIFT;
      end
      if (refr) begin
        nstatic = 0;
        for (int i = 0; i < 3; i++) begin
          p = pos16(f[i]);
          n = pos16(f[3 + i]);
          hf = (p + n) / 2;
          p75 = p / 2 + p / 4;
          n75 = n / 2 + n / 4;
          if (hf < p75 || hf < n75) nstatic++;
        end
        static_vec = (nstatic >= 2);
        for (int i = 0; i < 3; i++) ph[i] = (cavg[i] < floor_curr) ? 1 : cavg[i];
        sum = ph[0] + ph[1] + ph[2];
        valid_smp = (sum / 3) > floor_curr;
        curr_sym = pairs_within(ph, thr_curr, peak_c);
        volt_sym = pairs_within(vavg, thr_volt, peak_v);
      end
      any_zero = 1'b0;
      for (int i = 0; i < 3; i++)
        if (vavg[i] > floor_volt && cavg[i] < floor_curr) any_zero = 1'b1;
      if ((!volt_sym || !curr_sym) && valid_smp && !static_vec) begin
        corrupted = 1'b1;
        if (any_zero) lost_q = 1'b1;
        else asym_q = 1'b1;
      end else begin
        lost_q = 1'b0;
        asym_q = 1'b0;
      end
      if (corrupted) begin
        if (err_cnt != 16'hFFFF) err_cnt++;
      end else if (err_cnt != 0) begin
        err_cnt--;
      end
    end
    st.fault = err_cnt > err_limit;
    st.corrupted = corrupted;
    st.lost = lost_q;
    st.asym = asym_q;
    st.count = err_cnt;
    st.vdiff = peak_v;
    st.cdiff = peak_c;
    expected_status.push_back(st);
  endtask

  // Sends one word, with a random idle gap first, and predicts its effect.
  // Valid stays high after acceptance so that words can follow back to back;
  // an idle gap or a drain drops it.
  task automatic send_word(logic kind, logic spin, logic refr, logic [15:0] f[6]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind; spinning_i <= spin; refresh_i <= refr;
    cur_a_i <= f[0]; cur_b_i <= f[1]; cur_c_i <= f[2];
    volt_a_i <= f[3]; volt_b_i <= f[4]; volt_c_i <= f[5];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(kind, spin, refr, f);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_VOLT_ASYM:  thr_volt = val[6:0];
      CFG_CURR_ASYM:  thr_curr = val[6:0];
      CFG_CURR_FLOOR: floor_curr = val[14:0];
      CFG_VOLT_FLOOR: floor_volt = val[14:0];
      CFG_ERR_LIMIT:  err_limit = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(int tv, int tc, int fc, int fv, int lim);
    wait_drained();
    write_reg(CFG_VOLT_ASYM, 16'(tv));
    write_reg(CFG_CURR_ASYM, 16'(tc));
    write_reg(CFG_CURR_FLOOR, 16'(fc));
    write_reg(CFG_VOLT_FLOOR, 16'(fv));
    write_reg(CFG_ERR_LIMIT, 16'(lim));
  endtask

  // A balanced sample around the given magnitudes, with a random sign.
  task automatic send_sample(int ca, int cb, int cc, int va, int vb, int vc);
    logic [15:0] f[6];
    int m[6];
    m = '{ca, cb, cc, va, vb, vc};
    for (int i = 0; i < 6; i++) f[i] = $urandom_range(1) ? 16'(m[i]) : 16'(-m[i]);
    send_word(KIND_SAMPLE, 1'b1, 1'b0, f);
  endtask

  task automatic send_check(logic spin, logic refr, int pa, int pb, int pc,
                            int na, int nb, int nc);
    logic [15:0] f[6];
    f = '{16'(pa), 16'(pb), 16'(pc), 16'(na), 16'(nb), 16'(nc)};
    send_word(KIND_CHECK, spin, refr, f);
  endtask

  // Field extremes, idle motor, both checks and zero divisors.
  task automatic test_directed();
    logic [15:0] f[6];
    send_check(1'b1, 1'b1, 0, 0, 0, 0, 0, 0);
    f = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
    send_word(KIND_SAMPLE, 1'b1, 1'b0, f);
    send_word(KIND_SAMPLE, 1'b0, 1'b1, f);
    send_word(KIND_CHECK, 1'b0, 1'b1, f);
    send_word(KIND_CHECK, 1'b1, 1'b1, f);
    f = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
    send_word(KIND_CHECK, 1'b1, 1'b1, f);
    send_check(1'b1, 1'b0, 100, 100, 100, 100, 100, 100);
    send_check(1'b1, 1'b1, 1000, 1000, 1000, 1000, 1000, 1000);
    send_check(1'b1, 1'b1, 4000, 100, 100, 100, 4000, 4000);
    for (int i = 0; i < 8; i++) send_sample(32768, 32768, 0, 32768, 32768, 32768);
    send_check(1'b1, 1'b1, 1000, 1000, 1000, 1000, 1000, 1000);
    send_check(1'b1, 1'b0, 1000, 1000, 1000, 1000, 1000, 1000);
  endtask

  // Mixes random words, checks and runs of big samples in which phase c is at
  // times pulled down, so that checks see lost and asymmetric phases.
  task automatic test_random(int n);
    int ca, cb, cc, va, vb, vc, p, q, sent;
    logic [15:0] f[6];
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0: begin
          for (int i = 0; i < 6; i++) f[i] = 16'($urandom);
          send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), f);
          sent++;
        end
        1, 2, 3, 4, 5: begin
          ca = $urandom_range(32768); cb = $urandom_range(32768);
          cc = $urandom_range(3) == 0 ? $urandom_range(200) : $urandom_range(32768);
          va = $urandom_range(32768); vb = $urandom_range(32768);
          vc = $urandom_range(32768);
          repeat ($urandom_range(1, 4)) begin
            send_sample(ca, cb, cc, va, vb, vc);
            sent++;
          end
        end
        default: begin
          p = $urandom_range(32767);
          q = $urandom_range(32767);
          if ($urandom_range(1)) send_check(1'b1, $urandom_range(3) != 0,
                                            p, p, p, q, q, q);
          else send_check($urandom_range(7) != 0, 1'($urandom_range(1)),
                          $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535));
          sent++;
        end
      endcase
    end
  endtask

  // Result checker: one comparison per accepted result word.
  always @(posedge clk_i) begin
    status_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checks_seen++;
      if (expected_status.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_s = expected_status.pop_front();
        if (fault_o !== exp_s.fault) begin
          $error("fault expected %0d got %0d", exp_s.fault, fault_o); errors++;
        end
        if (phase_corrupted_o !== exp_s.corrupted) begin
          $error("phase_corrupted expected %0d got %0d", exp_s.corrupted,
                 phase_corrupted_o); errors++;
        end
        if (phase_lost_o !== exp_s.lost) begin
          $error("phase_lost expected %0d got %0d", exp_s.lost, phase_lost_o); errors++;
        end
        if (phase_asymmetric_o !== exp_s.asym) begin
          $error("phase_asymmetric expected %0d got %0d", exp_s.asym,
                 phase_asymmetric_o); errors++;
        end
        if (error_count_o !== exp_s.count) begin
          $error("error_count expected %0d got %0d", exp_s.count, error_count_o); errors++;
        end
        if (max_volt_diff_o !== exp_s.vdiff) begin
          $error("max_volt_diff expected %0d got %0d", exp_s.vdiff, max_volt_diff_o);
          errors++;
        end
        if (max_curr_diff_o !== exp_s.cdiff) begin
          $error("max_curr_diff expected %0d got %0d", exp_s.cdiff, max_curr_diff_o);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at random at the configured rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reset_monitor_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    // Low thresholds and floors with a small limit so the fault can trip.
    write_all(0, 0, 0, 0, 0);
    test_random(275);
    send_idle_pct = 65;
    write_all(100, 100, 32767, 32767, 65535);
    test_random(275);
    send_idle_pct = 0;
    stall_pct = 65;
    write_all(10, 5, 300, 200, 3);
    test_random(275);
    send_idle_pct = 38;
    stall_pct = 38;
    write_all(20, 20, 600, 400, 700);
    write_reg(CFG_UNUSED, 16'hFFFF);
    test_random(275);
    wait_drained();
    $display("Sent %0d words; %0d check results compared over five register settings.",
             words_sent, checks_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ motor_phase_loss_detector_core.f @@
sv/mpld_pkg.sv
sv/mpld_div.sv
sv/motor_phase_loss_detector_core.sv
test/motor_phase_loss_detector_core_test.sv
